@@ rtl/msag_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msag_pkg: shared types and constants for the sensor average gather
// Channel count, sample widths and request/result payload structs.
// ----------------------------------------------------------------------------
package msag_pkg;
	localparam int NumChannels = 13;
	localparam int BufferDepth = 8;
	localparam int PosW        = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
	localparam int CntW        = $clog2(BufferDepth + 1);
	localparam int SampleW     = 16;
	localparam int SumW        = SampleW + $clog2(BufferDepth + 1);
	localparam int ChW         = 4;
	localparam int StoreDepth  = NumChannels * BufferDepth;
	localparam int AddrW       = $clog2(StoreDepth);
	localparam logic [NumChannels-1:0] MaskAll = '1;

	typedef struct packed {
		logic [ChW-1:0]            channel;
		logic signed [SampleW-1:0] sample;
	} in_req_t;

	typedef struct packed {
		logic [ChW-1:0]            out_channel;
		logic signed [SampleW-1:0] mean_value;
		logic                      last;
	} out_res_t;

	// front to back queue entry: a classified sample, flagged when it closes a package
	typedef struct packed {
		logic [ChW-1:0]            channel;
		logic signed [SampleW-1:0] sample;
		logic                      emit;
	} cmd_t;
endpackage
`default_nettype wire

@@ rtl/multichannel_sensor_average_gather.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_sensor_average_gather: 13-channel moving average with gather
// Keeps an 8-deep ring and running sum per channel; when every channel has
// delivered a sample, emits 13 means (truncated toward zero), last one marked.
//
//   port      dir   payload    handshake
//   in_*      in    in_req_t   in_valid / in_stall
//   out_*     out   out_res_t  out_valid / out_stall
//
// A sample passes the back end's read and update states (ring read, update); a
// closing sample then walks all 13 channels through the 20-step serial divider.
// A two-entry queue lets the front accept while the back end works.
// arst_n clears rings' positions, counts, sums and the pending mask.
// out_stall holds the result register and pauses the emission walk.
// ----------------------------------------------------------------------------
module multichannel_sensor_average_gather import msag_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire in_req_t in_data,
	output logic         out_valid,
	input  wire logic    out_stall,
	output out_res_t     out_data
);
	logic cmd_valid, cmd_pop;
	cmd_t cmd_data;

	msag_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.cmd_valid, .cmd_pop, .cmd_data
	);

	msag_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_pop, .cmd_data,
		.out_valid, .out_stall, .out_data
	);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	// last only on the final channel
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == (out_data.out_channel == ChW'(NumChannels - 1))))
		else $error("last flag on wrong channel");
	// channel number in range
	a_ch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.out_channel < ChW'(NumChannels))
		else $error("result channel out of range");
endmodule
`default_nettype wire

@@ rtl/msag_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msag_front: request classifier
// Drops out-of-range channels, tracks the pending mask and marks the sample
// that completes a package. Holds a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module msag_front import msag_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire in_req_t in_data,
	output logic         cmd_valid,
	input  wire logic    cmd_pop,
	output cmd_t         cmd_data
);
	logic [NumChannels-1:0] mask_q;
	cmd_t                   fifo_q [2];
	logic                   rd_q, wr_q;
	logic [1:0]             cnt_q;
	logic                   take, in_range, push;
	logic [NumChannels-1:0] clr, next_mask;

	assign in_stall  = (cnt_q == 2'd2);
	assign take      = in_valid && !in_stall;
	assign in_range  = (in_data.channel < ChW'(NumChannels));
	assign push      = take && in_range;
	assign clr       = NumChannels'(1) << in_data.channel;
	assign next_mask = mask_q & ~clr;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd_data  = fifo_q[rd_q];

	// mask and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MaskAll;
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				mask_q <= (next_mask == '0) ? MaskAll : next_mask;
				wr_q   <= ~wr_q;
			end
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q].channel <= in_data.channel;
			fifo_q[wr_q].sample  <= in_data.sample;
			fifo_q[wr_q].emit    <= (next_mask == '0);
		end
	end
endmodule
`default_nettype wire

@@ rtl/msag_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msag_back: ring update and package emission
// Updates one channel's ring and sum per command; on a closing command walks
// all channels through a serial restoring divider and emits their means.
// ----------------------------------------------------------------------------
module msag_back import msag_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_pop,
	input  wire cmd_t cmd_data,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_res_t  out_data
);
	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_UPD, ST_DLOAD, ST_DIV, ST_OUT} st_t;
	localparam int DivCntW = $clog2(SumW + 1);

	st_t                       st_q;
	logic signed [SampleW-1:0] mem [StoreDepth];
	logic signed [SampleW-1:0] rd_data_q;
	logic [PosW-1:0]           pos_q [NumChannels];
	logic [CntW-1:0]           fill_q [NumChannels];
	logic signed [SumW-1:0]    sum_q [NumChannels];
	cmd_t                      cmd_q;
	logic [ChW-1:0]            ch_q;
	logic [SumW-1:0]           quo_q, rem_q, dvd_q;
	logic [CntW-1:0]           dsr_q;
	logic                      neg_q;
	logic [DivCntW-1:0]        dcnt_q;
	out_res_t                  res_q;
	logic                      res_valid_q;

	logic [AddrW-1:0]          addr;
	logic [3:0]                cc;
	logic [SumW:0]             trial;
	logic [SumW-1:0]           shl;
	logic signed [SumW-1:0]    s_cur;
	logic [SumW-1:0]           quo_fix;

	assign cc      = cmd_q.channel;
	assign addr    = AddrW'(cc) * AddrW'(BufferDepth) + AddrW'(pos_q[cc]);
	assign cmd_pop = (st_q == ST_IDLE) && cmd_valid;
	assign shl     = {rem_q[SumW-2:0], dvd_q[SumW-1]};
	assign trial   = {1'b0, shl} - {{(SumW + 1 - CntW){1'b0}}, dsr_q};
	assign s_cur   = sum_q[ch_q];
	assign quo_fix = neg_q ? -quo_q : quo_q;
	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	// ring store, read data registered
	always_ff @(posedge clk) begin
		if (st_q == ST_READ) rd_data_q <= mem[addr];
		if (st_q == ST_UPD) mem[addr] <= cmd_q.sample;
	end

	// sequencer, per-channel state and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			res_valid_q <= 1'b0;
			ch_q        <= '0;
			dcnt_q      <= '0;
			for (int i = 0; i < NumChannels; i++) begin
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
				sum_q[i]  <= '0;
			end
		end else begin
			// result taken; ST_OUT handles its own refill
			if (res_valid_q && !out_stall && st_q != ST_OUT) res_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (cmd_valid) begin
					cmd_q <= cmd_data;
					st_q  <= ST_READ;
				end
				ST_READ: st_q <= ST_UPD;
				ST_UPD: begin
					if (fill_q[cc] == CntW'(BufferDepth))
						sum_q[cc] <= sum_q[cc] - SumW'(rd_data_q) + SumW'(cmd_q.sample);
					else begin
						sum_q[cc]  <= sum_q[cc] + SumW'(cmd_q.sample);
						fill_q[cc] <= fill_q[cc] + CntW'(1);
					end
					pos_q[cc] <= (pos_q[cc] == PosW'(BufferDepth - 1)) ? '0 : pos_q[cc] + PosW'(1);
					ch_q <= '0;
					st_q <= cmd_q.emit ? ST_DLOAD : ST_IDLE;
				end
				ST_DLOAD: begin
					neg_q  <= s_cur[SumW-1];
					dvd_q  <= s_cur[SumW-1] ? SumW'(-s_cur) : SumW'(s_cur);
					dsr_q  <= fill_q[ch_q];
					rem_q  <= '0;
					quo_q  <= '0;
					dcnt_q <= DivCntW'(SumW);
					st_q   <= ST_DIV;
				end
				ST_DIV: begin
					// one restoring step per cycle
					dvd_q <= {dvd_q[SumW-2:0], 1'b0};
					if (!trial[SumW]) begin
						rem_q <= trial[SumW-1:0];
						quo_q <= {quo_q[SumW-2:0], 1'b1};
					end else begin
						rem_q <= shl;
						quo_q <= {quo_q[SumW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - DivCntW'(1);
					if (dcnt_q == DivCntW'(1)) st_q <= ST_OUT;
				end
				ST_OUT: if (!res_valid_q || !out_stall) begin
					res_valid_q       <= 1'b1;
					res_q.out_channel <= ch_q;
					res_q.mean_value  <= (dsr_q == '0) ? '0 : quo_fix[SampleW-1:0];
					res_q.last        <= (ch_q == ChW'(NumChannels - 1));
					ch_q <= ch_q + ChW'(1);
					st_q <= (ch_q == ChW'(NumChannels - 1)) ? ST_IDLE : ST_DLOAD;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
